@@ src/box_blur_3x3_rgb_clamped_assert.svh @@
// Assertion macros used by the checker of the box blur block.
`ifndef BOX_BLUR_3X3_RGB_CLAMPED_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_CLAMPED_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define BBLUR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box blur check failed");

// Check cons in the cycle after ante, outside reset.
`define BBLUR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("box blur check failed");

// Check cons in the cycle after ante, reset included.
`define BBLUR_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("box blur check failed");

`endif

@@ src/bblur_pkg.sv @@
`timescale 1ns / 1ps

package bblur_pkg;

   localparam int DEF_MAX_WIDTH      = 1024;
   localparam int DEF_MAX_HEIGHT     = 4096;

   localparam int CFG_WIDTH_BITS     = 11;
   localparam int CFG_HEIGHT_BITS    = 13;
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 13;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_BITS'(1);

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   // floor(x / 9) == (x * 3641) >> 15 for every x below 32768
   localparam int RECIP_NINE  = 3641;
   localparam int RECIP_SHIFT = 15;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   typedef struct packed {
      logic       action;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_end;
   } rsp_type;

endpackage

@@ src/box_blur_3x3_rgb_clamped.sv @@
`timescale 1ns / 1ps
// 3x3 mean blur of a raster-order stream of 24-bit RGB pixels.
// req channel: one item per pixel (action pixel) or per drain (action drain).
// After the last pixel of a frame, width+1 drain items release the remaining
// results; drains before the frame is complete give nothing and are dropped.
// rsp channel: one blurred pixel per result, frame_end set on the last one.
// The result for a pixel is caused by the item width+1 positions later and
// reaches rsp through the stage 1, stage 2 and result registers.
// Throughput: one item per clock when not stalled. The two line stores are
// read/written once per cycle; an item reads its column before writing it back.
// csr channel: index 0 frame_width, index 1 frame_height, always ready.
// A write to either restarts the frame; write only while the block is idle.
// Reset: sizes return to 640x480, the frame restarts and the pipeline empties;
// the line stores keep their contents.
// rsp_stall holds the result register; up to two more items that produce a
// result are taken into the pipeline before req_stall rises, and items that
// produce none keep flowing.

module box_blur_3x3_rgb_clamped #(
   parameter int MAX_WIDTH  = bblur_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bblur_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bblur_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bblur_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bblur_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bblur_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bblur_pkg::*;

   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int WW        = $clog2(MAX_WIDTH + 1);
   localparam int HW        = $clog2(MAX_HEIGHT + 1);
   localparam int RW        = $clog2(MAX_HEIGHT + 3);
   localparam int CSUM_BITS = 10;
   localparam int TOTAL_BITS = 12;
   localparam int PROD_BITS = 24;

   typedef struct packed {
      logic [CSUM_BITS-1:0] red;
      logic [CSUM_BITS-1:0] green;
      logic [CSUM_BITS-1:0] blue;
   } colsum_type;

   typedef struct packed {
      logic      line;
      logic      wr;
      logic      r_ge2;
      logic      r_eq_h;
      logic      emit_pre;
      logic      emit_post;
      logic      c_eq1;
      logic      last;
      pixel_type pix;
   } stage_type;

   function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
      logic [31:0] res;
      if (v == 32'd0) begin
         res = 32'd1;
      end else if (v > hi) begin
         res = hi;
      end else begin
         res = v;
      end
      return res;
   endfunction

   function automatic colsum_type col_sum(input pixel_type a, input pixel_type b,
                                          input pixel_type c);
      colsum_type s;
      s.red   = CSUM_BITS'(a.red)   + CSUM_BITS'(b.red)   + CSUM_BITS'(c.red);
      s.green = CSUM_BITS'(a.green) + CSUM_BITS'(b.green) + CSUM_BITS'(c.green);
      s.blue  = CSUM_BITS'(a.blue)  + CSUM_BITS'(b.blue)  + CSUM_BITS'(c.blue);
      return s;
   endfunction

   function automatic logic [7:0] mean9(input logic [CSUM_BITS-1:0] a,
                                        input logic [CSUM_BITS-1:0] b,
                                        input logic [CSUM_BITS-1:0] c);
      logic [TOTAL_BITS-1:0] total;
      logic [PROD_BITS-1:0]  prod;
      total = TOTAL_BITS'(a) + TOTAL_BITS'(b) + TOTAL_BITS'(c);
      prod  = PROD_BITS'(total) * PROD_BITS'(RECIP_NINE);
      return prod[RECIP_SHIFT +: 8];
   endfunction

   // sizes and stream positions
   logic [WW-1:0] eff_w_ff, eff_w_in;
   logic [HW-1:0] eff_h_ff, eff_h_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] ocol_ff, ocol_in;
   logic [RW-1:0] orow_ff, orow_in;

   // pipeline
   logic          s1_valid_ff, s1_valid_in;
   stage_type     s1_ff, s1_in;
   logic [CW-1:0] s1_addr_ff;
   logic          fwd_ff, fwd_in;
   line_pair_type fwd_data_ff;
   colsum_type    colsum_ff [3];
   colsum_type    win_next  [3];
   logic          s2_valid_ff, s2_valid_in;
   colsum_type    s2_a_ff, s2_b_ff, s2_c_ff;
   colsum_type    sel_a, sel_b, sel_c;
   logic          s2_last_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_in;

   logic          csr_wr, csr_restart;
   logic          acc, out_ready, s2_take, s1_go, s1_emit;
   logic          restart, drop, emit, last, col_wrap, ocol_wrap;
   logic [CW:0]   w_ext, c_inc, oc_inc;
   logic [RW-1:0] h_ext, or_inc;
   logic [CW-1:0] c0, oc0;
   logic [RW-1:0] r0, or0;
   line_pair_type mem_rd, line_q, wr_pair;
   pixel_type     top_pix, mid_pix, bot_pix;
   colsum_type    new_col;

   assign csr_ready   = 1'b1;
   assign csr_wr      = csr_valid && csr_ready;
   assign csr_restart = csr_wr && (csr_index == CSR_FRAME_WIDTH ||
                                   csr_index == CSR_FRAME_HEIGHT);

   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_wr && csr_index == CSR_FRAME_WIDTH) begin
         eff_w_in = WW'(clamp_size(32'(csr_data[CFG_WIDTH_BITS-1:0]), 32'(MAX_WIDTH)));
      end
      if (csr_wr && csr_index == CSR_FRAME_HEIGHT) begin
         eff_h_in = HW'(clamp_size(32'(csr_data[CFG_HEIGHT_BITS-1:0]), 32'(MAX_HEIGHT)));
      end
   end

   // handshake
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_take   = !s2_valid_ff || out_ready;
   assign s1_emit   = s1_ff.emit_pre || s1_ff.emit_post;
   assign s1_go     = s1_valid_ff && (!s1_emit || s2_take);
   assign req_stall = s1_valid_ff && !s1_go;
   assign acc       = req_valid && !req_stall;

   // position of the arriving item
   always_comb begin
      w_ext     = (CW+1)'(eff_w_ff);
      h_ext     = RW'(eff_h_ff);
      restart   = ({1'b0, col_ff} >= w_ext) || (row_ff > h_ext + RW'(1));
      c0        = restart ? '0 : col_ff;
      r0        = restart ? '0 : row_ff;
      oc0       = restart ? '0 : ocol_ff;
      or0       = restart ? '0 : orow_ff;
      drop      = (r0 < h_ext) && (req_data.action == ACTION_DRAIN);
      c_inc     = {1'b0, c0} + (CW+1)'(1);
      oc_inc    = {1'b0, oc0} + (CW+1)'(1);
      or_inc    = or0 + RW'(1);
      col_wrap  = c_inc >= w_ext;
      ocol_wrap = oc_inc >= w_ext;

      s1_in.line      = r0 <= h_ext;
      s1_in.wr        = r0 < h_ext;
      s1_in.r_ge2     = r0 >= RW'(2);
      s1_in.r_eq_h    = r0 == h_ext;
      s1_in.emit_pre  = (c0 == '0) && (r0 >= RW'(2));
      s1_in.emit_post = (c0 != '0) && (r0 != '0);
      s1_in.c_eq1     = c0 == CW'(1);
      s1_in.pix.red   = req_data.red;
      s1_in.pix.green = req_data.green;
      s1_in.pix.blue  = req_data.blue;
      emit            = s1_in.emit_pre || s1_in.emit_post;
      last            = emit && (or_inc >= h_ext) && ocol_wrap;
      s1_in.last      = last;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      priority if (csr_restart) begin
         col_in  = '0;
         row_in  = '0;
         ocol_in = '0;
         orow_in = '0;
      end else if (acc && drop) begin
         col_in  = c0;
         row_in  = r0;
         ocol_in = oc0;
         orow_in = or0;
      end else if (acc) begin
         col_in  = col_wrap ? '0 : c_inc[CW-1:0];
         row_in  = col_wrap ? r0 + RW'(1) : r0;
         ocol_in = oc0;
         orow_in = or0;
         if (emit) begin
            ocol_in = ocol_wrap ? '0 : oc_inc[CW-1:0];
            orow_in = ocol_wrap ? or_inc : or0;
         end
         if (last) begin
            col_in  = '0;
            row_in  = '0;
            ocol_in = '0;
            orow_in = '0;
         end
      end else begin
         col_in  = col_ff;
      end
   end

   // stage 1: line stores, window update, column selection
   always_comb begin
      line_q  = fwd_ff ? fwd_data_ff : mem_rd;
      mid_pix = line_q.middle;
      top_pix = s1_ff.r_ge2 ? line_q.upper : mid_pix;
      bot_pix = s1_ff.r_eq_h ? mid_pix : s1_ff.pix;
      new_col = col_sum(top_pix, mid_pix, bot_pix);
      wr_pair.upper  = mid_pix;
      wr_pair.middle = bot_pix;

      if (s1_ff.line) begin
         win_next[0] = colsum_ff[1];
         win_next[1] = colsum_ff[2];
         win_next[2] = new_col;
      end else begin
         win_next[0] = colsum_ff[0];
         win_next[1] = colsum_ff[1];
         win_next[2] = colsum_ff[2];
      end

      if (s1_ff.emit_pre) begin
         sel_a = (eff_w_ff >= WW'(2)) ? colsum_ff[1] : colsum_ff[2];
         sel_b = colsum_ff[2];
         sel_c = colsum_ff[2];
      end else begin
         sel_a = s1_ff.c_eq1 ? win_next[1] : win_next[0];
         sel_b = win_next[1];
         sel_c = win_next[2];
      end
   end

   assign fwd_in = acc && !drop && s1_go && s1_ff.wr && (s1_addr_ff == c0);

   bblur_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (acc),
      .rd_addr (c0),
      .rd_data (mem_rd),
      .wr_en   (s1_go && s1_ff.wr),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_pair)
   );

   always_comb begin
      if (acc) begin
         s1_valid_in = !drop;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_go && s1_emit) begin
         s2_valid_in = 1'b1;
      end else if (out_ready) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end

      rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;

      rsp_in.out_red   = mean9(s2_a_ff.red,   s2_b_ff.red,   s2_c_ff.red);
      rsp_in.out_green = mean9(s2_a_ff.green, s2_b_ff.green, s2_c_ff.green);
      rsp_in.out_blue  = mean9(s2_a_ff.blue,  s2_b_ff.blue,  s2_c_ff.blue);
      rsp_in.frame_end = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff     <= WW'(clamp_size(32'(FRAME_WIDTH_RESET), 32'(MAX_WIDTH)));
         eff_h_ff     <= HW'(clamp_size(32'(FRAME_HEIGHT_RESET), 32'(MAX_HEIGHT)));
         col_ff       <= '0;
         row_ff       <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         eff_w_ff     <= eff_w_in;
         eff_h_ff     <= eff_h_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (acc) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ff      <= s1_in;
         s1_addr_ff <= c0;
         if (fwd_in) begin
            fwd_data_ff <= wr_pair;
         end
      end
      if (s1_go) begin
         colsum_ff[0] <= win_next[0];
         colsum_ff[1] <= win_next[1];
         colsum_ff[2] <= win_next[2];
      end
      if (s1_go && s1_emit) begin
         s2_a_ff    <= sel_a;
         s2_b_ff    <= sel_b;
         s2_c_ff    <= sel_c;
         s2_last_ff <= s1_ff.last;
      end
      if (out_ready && s2_valid_ff) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/bblur_line_buf.sv @@
`timescale 1ns / 1ps

module bblur_line_buf #(
   parameter int MAX_WIDTH = bblur_pkg::DEF_MAX_WIDTH,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output bblur_pkg::line_pair_type  rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  bblur_pkg::line_pair_type  wr_data
);
   import bblur_pkg::*;

   pixel_type     upper_mem  [MAX_WIDTH];
   pixel_type     middle_mem [MAX_WIDTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_data.upper;
         middle_mem[wr_addr] <= wr_data.middle;
      end
      if (rd_en) begin
         rd_data_ff.upper  <= upper_mem[rd_addr];
         rd_data_ff.middle <= middle_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bblur_check.sv @@
`timescale 1ns / 1ps
`include "box_blur_3x3_rgb_clamped_assert.svh"

module bblur_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input bblur_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input bblur_pkg::rsp_type rsp_data
);

   // hold a stalled item
   `BBLUR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // an empty result register never pushes back on the input
   `BBLUR_ASSERT_NOW(a_input_free, !rsp_valid, !req_stall)

   // reset empties the pipeline
   `BBLUR_ASSERT_ALWAYS_NEXT(a_reset_empty, reset, !rsp_valid && !req_stall)

   // hold a waiting input item
   `BBLUR_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_data))

endmodule

bind box_blur_3x3_rgb_clamped bblur_check u_bblur_check (.*);

@@ verif/box_blur_checker.sv @@
`timescale 1ns / 1ps

module box_blur_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  bblur_pkg::req_type                   req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  bblur_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [bblur_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bblur_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   checked_count
);
   import bblur_pkg::*;

   logic [CFG_WIDTH_BITS-1:0]  width_reg;
   logic [CFG_HEIGHT_BITS-1:0] height_reg;
   pixel_type                  upper_mem [DEF_MAX_WIDTH];
   pixel_type                  middle_mem [DEF_MAX_WIDTH];
   pixel_type                  win [9];
   int unsigned                in_col, in_row, out_col, out_row;
   rsp_type                    blurred_q [$];
   rsp_type                    want;
   int                         fails = 0;
   int                         checked = 0;

   initial begin
      fail_count = 0;
      pending = 0;
      checked_count = 0;
   end

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
      return 32'(height_reg);
   endfunction

   function automatic void restart_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic pixel_type window_mean(int ca, int cb, int cc);
      int        cols [3];
      int        sr, sg, sb;
      pixel_type px;
      cols[0] = ca;
      cols[1] = cb;
      cols[2] = cc;
      sr = 0;
      sg = 0;
      sb = 0;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            sr += win[cols[k] * 3 + j].red;
            sg += win[cols[k] * 3 + j].green;
            sb += win[cols[k] * 3 + j].blue;
         end
      end
      px.red   = 8'(sr / 9);
      px.green = 8'(sg / 9);
      px.blue  = 8'(sb / 9);
      return px;
   endfunction

   function automatic void blur_advance(req_type item);
      int unsigned w, h, c, r;
      pixel_type   top_px, mid_px, bot_px, blur_px;
      rsp_type     res;
      bit          emitted, last;
      w = eff_width();
      h = eff_height();
      c = in_col;
      r = in_row;
      top_px = '0;
      mid_px = '0;
      bot_px = '0;
      blur_px = '0;
      emitted = 1'b0;
      if (c >= w || r > h + 1) begin
         restart_frame();
         c = 0;
         r = 0;
      end
      if (r < h) begin
         if (item.action == ACTION_DRAIN) return;
         bot_px = {item.red, item.green, item.blue};
      end
      if (r <= h) begin
         mid_px = middle_mem[c];
         top_px = (r >= 2) ? upper_mem[c] : mid_px;
         if (r == h) bot_px = mid_px;
         if (r < h) begin
            upper_mem[c] = middle_mem[c];
            middle_mem[c] = bot_px;
         end
      end
      // right edge of the row two back, from the window before it shifts
      if (c == 0 && r >= 2) begin
         blur_px = window_mean((w >= 2) ? 1 : 2, 2, 2);
         emitted = 1'b1;
      end
      if (r <= h) begin
         for (int k = 0; k < 6; k++) win[k] = win[k + 3];
         win[6] = top_px;
         win[7] = mid_px;
         win[8] = bot_px;
      end
      if (c >= 1 && r >= 1) begin
         blur_px = window_mean((c == 1) ? 1 : 0, 1, 2);
         emitted = 1'b1;
      end
      in_col = c + 1;
      if (in_col >= w) begin
         in_col = 0;
         in_row = r + 1;
      end
      if (!emitted) return;
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.out_red   = blur_px.red;
      res.out_green = blur_px.green;
      res.out_blue  = blur_px.blue;
      res.frame_end = last;
      blurred_q.push_back(res);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (last) restart_frame();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg = CFG_WIDTH_BITS'(FRAME_WIDTH_RESET);
         height_reg = CFG_HEIGHT_BITS'(FRAME_HEIGHT_RESET);
         for (int k = 0; k < DEF_MAX_WIDTH; k++) begin
            upper_mem[k] = '0;
            middle_mem[k] = '0;
         end
         for (int k = 0; k < 9; k++) win[k] = '0;
         restart_frame();
         blurred_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               width_reg = csr_data[CFG_WIDTH_BITS-1:0];
               restart_frame();
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               height_reg = csr_data[CFG_HEIGHT_BITS-1:0];
               restart_frame();
            end
         end
         if (req_valid && !req_stall) blur_advance(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (blurred_q.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected blurred pixel r=%0h g=%0h b=%0h end=%0b", $time,
                           rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue,
                           rsp_data.frame_end);
            end else begin
               want = blurred_q.pop_front();
               checked++;
               if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green ||
                   rsp_data.out_blue !== want.out_blue ||
                   rsp_data.frame_end !== want.frame_end) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: pixel %0d exp %h %h %h end %0b, got %h %h %h end %0b",
                              $time, checked, want.out_red, want.out_green, want.out_blue,
                              want.frame_end, rsp_data.out_red, rsp_data.out_green,
                              rsp_data.out_blue, rsp_data.frame_end);
               end
            end
         end
      end
      fail_count <= fails;
      pending <= blurred_q.size();
      checked_count <= checked;
   end

endmodule

@@ verif/box_blur_3x3_rgb_clamped_tb.sv @@
`timescale 1ns / 1ps

module box_blur_3x3_rgb_clamped_tb;
   import bblur_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = CSR_INDEX_BITS'(3);

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int fail_count, pending, checked_count;
   bit calm = 1'b0;
   int stall_left = 0;
   int stall_draw;
   int pixels_sent = 0;
   int drains_sent = 0;
   int frames_run = 0;

   always #5 clock = ~clock;

   box_blur_3x3_rgb_clamped u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   box_blur_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = calm ? 0 : $urandom_range(0, 14);
         stall_left <= stall_draw;
         rsp_stall <= (stall_draw > 0);
      end
   end

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {act, r, g, b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ACTION_PIXEL) pixels_sent++;
      else drains_sent++;
   endtask

   task automatic send_random(logic act);
      send_item(act, rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int wv, int hv);
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_FRAME_WIDTH, CSR_DATA_BITS'(wv));
         write_csr(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(hv));
      end else begin
         write_csr(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(hv));
         write_csr(CSR_FRAME_WIDTH, CSR_DATA_BITS'(wv));
      end
   endtask

   // drop valid, wait out every expected pixel, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_frame(int w, int h, bit noisy);
      for (int i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(0, 15) == 0) send_random(ACTION_DRAIN);
         send_random(ACTION_PIXEL);
      end
      for (int i = 0; i <= w; i++) begin
         if (noisy && $urandom_range(0, 3) == 0) send_random(ACTION_PIXEL);
         else send_random(ACTION_DRAIN);
      end
      if (noisy && $urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3)) send_random(ACTION_DRAIN);
      frames_run++;
   endtask

   initial begin : stimulus
      int w, h;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      configure(3, 2);
      send_item(ACTION_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      send_item(ACTION_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_item(ACTION_PIXEL, 8'h00, 8'h00, 8'h00);
      send_item(ACTION_PIXEL, 8'hFF, 8'h00, 8'hFF);
      send_item(ACTION_DRAIN, 8'h00, 8'h00, 8'h00);
      send_item(ACTION_PIXEL, 8'h00, 8'hFF, 8'h00);
      send_item(ACTION_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_item(ACTION_PIXEL, 8'hFE, 8'h01, 8'h80);
      send_item(ACTION_DRAIN, 8'hAA, 8'h55, 8'hAA);
      send_item(ACTION_PIXEL, 8'h55, 8'hAA, 8'h55);
      send_item(ACTION_DRAIN, 8'h00, 8'hFF, 8'h00);
      send_item(ACTION_DRAIN, 8'hFF, 8'h00, 8'hFF);
      send_item(ACTION_DRAIN, 8'h0F, 8'hF0, 8'h0F);
      frames_run++;
      settle();

      configure(0, 0);
      send_item(ACTION_PIXEL, 8'h80, 8'h7F, 8'h01);
      send_random(ACTION_DRAIN);
      send_random(ACTION_DRAIN);
      send_random(ACTION_DRAIN);
      frames_run++;
      settle();

      // restart in the middle of a frame
      configure(4, 3);
      repeat (5) send_random(ACTION_PIXEL);
      settle();
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(2));
      run_frame(4, 2, 1'b0);
      settle();

      while (pixels_sent + drains_sent < 860) begin
         calm <= ($urandom_range(0, 3) == 0);
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         configure((w == 1 && $urandom_range(0, 1)) ? 0 : w,
                   (h == 1 && $urandom_range(0, 1)) ? 0 : h);
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, w * h)) send_random(ACTION_PIXEL);
         else run_frame(w, h, 1'b0 | 1'b1);
         settle();
         if ($urandom_range(0, 15) == 0) write_csr(CSR_SPARE, CSR_DATA_BITS'($urandom));
      end

      // oversized settings saturate to the largest width or height
      calm <= 1'($urandom_range(0, 1));
      configure(2047, 2);
      repeat (30) send_random(ACTION_PIXEL);
      settle();
      configure(2, 8191);
      repeat (40) send_random(ACTION_PIXEL);
      settle();

      $display("Ran %0d frames: %0d pixel items, %0d drain items, %0d blurred pixels compared.",
               frames_run, pixels_sent, drains_sent, checked_count);
      $display("Frames from 1x1 up to 48x12 plus oversized sizes, with restarts and stray drains.");
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/bblur_pkg.sv
src/bblur_line_buf.sv
src/box_blur_3x3_rgb_clamped.sv
src/bblur_check.sv
verif/box_blur_checker.sv
verif/box_blur_3x3_rgb_clamped_tb.sv
